[sv/top_k_select_with_zeroing_top_assert.svh]
// ----------------------------------------------------------------------------
// Top-K select with zeroing: assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SELECT_WITH_ZEROING_TOP_ASSERT_SVH
`define TOP_K_SELECT_WITH_ZEROING_TOP_ASSERT_SVH

// same-cycle implication
`define TKZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tkz_pkg.sv]
// ----------------------------------------------------------------------------
// tkz_pkg
// Types, constants and the control store of the top-K selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkz_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 6;
    localparam int STEP_W = 3;

    localparam logic [CFG_W-1:0] RESULT_LIMIT = CFG_W'(32);

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_EMIT_COUNT = 1'b1;

    localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SETUP = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_NEXT  = 3'd5;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_SCAN_END,
        C_OUT_BLOCK,
        C_LAST_ROUND
    } t_cond;

    typedef struct packed {
        logic accept;
        logic clr_scan;
        logic read;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic scan_end;
        logic out_block;
        logic last_round;
    } t_flags;

    typedef struct packed {
        t_ctrl             ctrl;
        t_cond             cond;
        logic [STEP_W-1:0] jt;
        logic [STEP_W-1:0] jf;
    } t_uword;

    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '0;
        w.cond = C_ALWAYS;
        case (addr)
            STEP_LOAD: begin
                w.ctrl.accept = 1'b1;
                w.cond        = C_START;
                w.jt          = STEP_SETUP;
                w.jf          = STEP_LOAD;
            end
            STEP_SETUP: begin
                w.ctrl.clr_scan = 1'b1;
                w.jt            = STEP_SCAN;
                w.jf            = STEP_SCAN;
            end
            STEP_SCAN: begin
                w.ctrl.read = 1'b1;
                w.cond      = C_SCAN_END;
                w.jt        = STEP_DRAIN;
                w.jf        = STEP_SCAN;
            end
            STEP_DRAIN: begin
                w.jt = STEP_EMIT;
                w.jf = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = C_OUT_BLOCK;
                w.jt        = STEP_EMIT;
                w.jf        = STEP_NEXT;
            end
            STEP_NEXT: begin
                w.cond = C_LAST_ROUND;
                w.jt   = STEP_LOAD;
                w.jf   = STEP_SETUP;
            end
            default: begin
                w.jt = STEP_LOAD;
                w.jf = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/tkz_seq.sv]
// ----------------------------------------------------------------------------
// tkz_seq
// Step counter and control store; branches on datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tkz_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  tkz_pkg::t_flags     i_flags,
    output tkz_pkg::t_ctrl      o_ctrl
);
    import tkz_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uword;
    logic              cond_true;

    assign uword  = ucode_rom(r_step);
    assign o_ctrl = uword.ctrl;

    always_comb begin
        case (uword.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_START:      cond_true = i_flags.start;
            C_SCAN_END:   cond_true = i_flags.scan_end;
            C_OUT_BLOCK:  cond_true = i_flags.out_block;
            C_LAST_ROUND: cond_true = i_flags.last_round;
            default:      cond_true = 1'b1;
        endcase
        n_step = cond_true ? uword.jt : uword.jf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[sv/tkz_dp.sv]
// ----------------------------------------------------------------------------
// tkz_dp
// Row memory, running maximum, round counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_k_select_with_zeroing_top_assert.svh"

module tkz_dp #(
    parameter int MAX_ROW_LENGTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  tkz_pkg::t_ctrl                    i_ctrl,
    output tkz_pkg::t_flags                   o_flags,
    input  wire logic [tkz_pkg::CFG_W-1:0]    i_row_length,
    input  wire logic [tkz_pkg::CFG_W-1:0]    i_emit_count,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [tkz_pkg::DATA_W-1:0] i_sample_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [tkz_pkg::DATA_W-1:0] o_max_value,
    output logic                              o_final_result
);
    import tkz_pkg::*;

    localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LW = $clog2(MAX_ROW_LENGTH + 1);

    logic [DATA_W-1:0]        mem [MAX_ROW_LENGTH];

    logic [LW-1:0]            r_loaded;
    logic [CFG_W-1:0]         r_rounds;
    logic [AW-1:0]            r_scan_idx;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_rd_vld;
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_best;
    logic [AW-1:0]            r_best_idx;
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_data;
    logic                     r_out_final;

    logic [LW-1:0]            len_eff;
    logic [CFG_W-1:0]         emit_eff;
    logic                     accept;
    logic                     row_full;
    logic                     out_block;
    logic                     emit_fire;

    always_comb begin
        if (i_row_length == '0) begin
            len_eff = LW'(1);
        end else if (32'(i_row_length) > 32'(MAX_ROW_LENGTH)) begin
            len_eff = LW'(MAX_ROW_LENGTH);
        end else begin
            len_eff = LW'(i_row_length);
        end
    end

    assign emit_eff   = (i_emit_count > RESULT_LIMIT) ? RESULT_LIMIT : i_emit_count;
    assign o_in_stall = !i_ctrl.accept;
    assign accept     = i_ctrl.accept && i_in_valid;
    assign row_full   = ({1'b0, r_loaded} + (LW+1)'(1)) >= {1'b0, len_eff};
    assign out_block  = r_out_vld && i_out_stall;
    assign emit_fire  = i_ctrl.emit && !out_block;

    assign o_flags.start      = i_in_valid && row_full && (emit_eff != '0);
    assign o_flags.scan_end   = LW'(r_scan_idx) == (len_eff - LW'(1));
    assign o_flags.out_block  = out_block;
    assign o_flags.last_round = r_rounds == emit_eff;

    // row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && (r_loaded < LW'(MAX_ROW_LENGTH))) begin
            mem[r_loaded[AW-1:0]] <= i_sample_value;
        end else if (emit_fire) begin
            mem[r_best_idx] <= '0;
        end
        if (i_ctrl.read) begin
            r_rd_data <= mem[r_scan_idx];
            r_rd_idx  <= r_scan_idx;
        end
    end

    // running maximum; ties move to the higher index
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && ((r_rd_idx == '0) || (r_rd_data >= r_best))) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (emit_fire) begin
            r_out_data  <= r_best;
            r_out_final <= (r_rounds + CFG_W'(1)) == emit_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_rounds   <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_ctrl.read;
            if (accept) begin
                if (row_full) begin
                    r_loaded <= '0;
                    r_rounds <= '0;
                end else begin
                    r_loaded <= r_loaded + LW'(1);
                end
            end else if (emit_fire) begin
                r_rounds <= r_rounds + CFG_W'(1);
            end
            if (i_ctrl.clr_scan) begin
                r_scan_idx <= '0;
            end else if (i_ctrl.read) begin
                r_scan_idx <= r_scan_idx + AW'(1);
            end
            if (emit_fire) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_max_value    = r_out_data;
    assign o_final_result = r_out_final;

    `TKZ_ASSERT_IMPL(a_scan_in_row, i_clk, i_rst_n, i_ctrl.read, LW'(r_scan_idx) < len_eff, "scan index beyond row length")
    `TKZ_ASSERT_IMPL(a_round_in_range, i_clk, i_rst_n, i_ctrl.read, r_rounds < emit_eff, "scan started after last round")
    `TKZ_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, emit_fire, r_out_vld && (r_rounds != '0), "emitted round not registered")

endmodule

`default_nettype wire

[sv/top_k_select_with_zeroing_top.sv]
// ----------------------------------------------------------------------------
// top_k_select_with_zeroing_top
// Top-K selection by repeated maximum, with an APB register port.
// ----------------------------------------------------------------------------
// Samples load one per cycle until row_length have arrived. The block then
// stalls its input and runs emit_count rounds; each round steps through
// setup, one read per entry through the single read port of the row memory,
// a drain step, the zero write with the output transfer, and a branch, and
// waits at the output transfer while the output is stalled. The last result
// of a row carries final_result. No clearing pass after reset.
`default_nettype none

module top_k_select_with_zeroing_top #(
    parameter int MAX_ROW_LENGTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [tkz_pkg::DATA_W-1:0] i_sample_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [tkz_pkg::DATA_W-1:0]      o_max_value,
    output logic                                   o_final_result
);
    import tkz_pkg::*;

    logic [CFG_W-1:0] r_row_length;
    logic [CFG_W-1:0] r_emit_count;
    logic             cfg_write;
    t_ctrl            ctrl;
    t_flags           flags;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= CFG_W'(32);
            r_emit_count <= CFG_W'(1);
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ROW_LENGTH: r_row_length <= pwdata[CFG_W-1:0];
                REG_EMIT_COUNT: r_emit_count <= pwdata[CFG_W-1:0];
                default:        r_row_length <= r_row_length;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_LENGTH: prdata = 32'(r_row_length);
            REG_EMIT_COUNT: prdata = 32'(r_emit_count);
            default:        prdata = '0;
        endcase
    end

    tkz_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    tkz_dp #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_flags        (flags),
        .i_row_length   (r_row_length),
        .i_emit_count   (r_emit_count),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_max_value    (o_max_value),
        .o_final_result (o_final_result)
    );

endmodule

`default_nettype wire

[test/max_select_checker.sv]
// ----------------------------------------------------------------------------
// max_select_checker
// Watches the register port and both data channels of the top-K selector,
// keeps its own copy of the row and of the registers, works out the maxima
// each completed row releases and compares every output transfer with them.
// ----------------------------------------------------------------------------
`default_nettype none

module max_select_checker #(
    parameter int MAX_ROW_LENGTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic                              i_pready,
    input  wire logic [2:0]                        i_paddr,
    input  wire logic [31:0]                       i_pwdata,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic signed [tkz_pkg::DATA_W-1:0] i_sample_value,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic signed [tkz_pkg::DATA_W-1:0] i_max_value,
    input  wire logic                              i_final_result,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import tkz_pkg::*;

    localparam int IDX_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_expected_max;

    t_expected_max            expected_maxima[$];
    t_expected_max            head;
    logic signed [DATA_W-1:0] row_mem [MAX_ROW_LENGTH];
    logic [CFG_W-1:0]         cfg_row_length;
    logic [CFG_W-1:0]         cfg_emit_count;
    int unsigned              fill_count;
    int unsigned              active_len;
    int                       mismatch_count;

    function automatic int unsigned effective_row_length();
        if (cfg_row_length == '0) begin
            return 1;
        end
        if (cfg_row_length > MAX_ROW_LENGTH) begin
            return MAX_ROW_LENGTH;
        end
        return 32'(cfg_row_length);
    endfunction

    // Repeated maximum: emit it, then clear its highest-index copy.
    task automatic select_maxima(input int unsigned len);
        int unsigned              rounds;
        int unsigned              r;
        int unsigned              i;
        logic                     cleared;
        logic signed [DATA_W-1:0] best;
        t_expected_max            entry;
        rounds = 32'((cfg_emit_count > RESULT_LIMIT) ? RESULT_LIMIT : cfg_emit_count);
        for (r = 0; r < rounds; r++) begin
            best = row_mem[0];
            for (i = 1; i < len; i++) begin
                if (row_mem[IDX_W'(i)] > best) begin
                    best = row_mem[IDX_W'(i)];
                end
            end
            cleared = 1'b0;
            for (i = len; i > 0 && !cleared; i--) begin
                if (row_mem[IDX_W'(i-1)] == best) begin
                    row_mem[IDX_W'(i-1)] = '0;
                    cleared              = 1'b1;
                end
            end
            entry.value = best;
            entry.last  = (r + 1 == rounds);
            expected_maxima.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_maxima.delete();
            fill_count     = 0;
            cfg_row_length = CFG_W'(32);
            cfg_emit_count = CFG_W'(1);
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_ROW_LENGTH, 2'b00}) begin
                    cfg_row_length = i_pwdata[CFG_W-1:0];
                end else if (i_paddr == {REG_EMIT_COUNT, 2'b00}) begin
                    cfg_emit_count = i_pwdata[CFG_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                active_len = effective_row_length();
                if (fill_count < MAX_ROW_LENGTH) begin
                    row_mem[IDX_W'(fill_count)] = i_sample_value;
                    fill_count++;
                end
                if (fill_count >= active_len) begin
                    select_maxima(active_len);
                    fill_count = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_maxima.size() == 0) begin
                    $display("%0t unexpected result: expected none, got max_value %0d final %0b",
                             $time, i_max_value, i_final_result);
                    mismatch_count++;
                end else begin
                    head = expected_maxima.pop_front();
                    if (i_max_value !== head.value) begin
                        $display("%0t max_value mismatch: expected %0d, got %0d",
                                 $time, head.value, i_max_value);
                        mismatch_count++;
                    end
                    if (i_final_result !== head.last) begin
                        $display("%0t final_result mismatch: expected %0b, got %0b",
                                 $time, head.last, i_final_result);
                        mismatch_count++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_maxima.size();
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives rows of signed samples and register settings into the top-K
// selector with random gaps and output stalls, one long output hold-off,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import tkz_pkg::*;

    localparam int MAX_ROW_LENGTH = 32;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_ITEMS   = 260;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_sample_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_max_value;
    logic                     o_final_result;

    int fail_count;
    int pending;
    int samples_sent;
    int gap_odds;
    bit tail_part;
    bit settling;
    bit hold_req;
    bit hold_served;

    top_k_select_with_zeroing_top #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_max_value    (o_max_value),
        .o_final_result (o_final_result)
    );

    max_select_checker #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_max_value    (o_max_value),
        .i_final_result (o_final_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int row_items(input logic [CFG_W-1:0] rl);
        if (rl == '0) begin
            return 1;
        end
        if (rl > MAX_ROW_LENGTH) begin
            return MAX_ROW_LENGTH;
        end
        return int'(rl);
    endfunction

    function automatic logic signed [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return DATA_W'(int'($urandom_range(0, 6)) - 3);
            1: return {1'b1, 31'($urandom())};
            2: return {1'b1, 31'b0};
            3: return {1'b0, {31{1'b1}}};
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {26'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        settling = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settling = 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] ec);
        quiesce();
        write_reg(REG_ROW_LENGTH, rl);
        write_reg(REG_EMIT_COUNT, ec);
        case ($urandom_range(0, 4))
            0: gap_odds = 0;
            1: gap_odds = 2;
            2: gap_odds = 3;
            3: gap_odds = 5;
            default: gap_odds = 8;
        endcase
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] value);
        if (!tail_part && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
    endtask

    task automatic send_row(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_sample(random_sample());
        end
    endtask

    // Output side: random stall bursts, calm stretches, one long hold-off.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
                i_out_stall <= 1'b0;
            end else if (!tail_part && !settling && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int               target;
        int               len;
        int               rows;
        logic [CFG_W-1:0] rl;
        logic [CFG_W-1:0] ec;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        samples_sent   = 0;
        gap_odds       = 0;
        tail_part      = 1'b0;
        settling       = 1'b0;
        hold_req       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, more rounds than entries, negatives losing to zeros
        configure(6'd4, 6'd6);
        send_sample({1'b1, 31'b0});
        send_sample({1'b0, {31{1'b1}}});
        send_sample(-32'sd5);
        send_sample(32'sd7);
        // zero row length acts as one
        configure(6'd0, 6'd2);
        send_sample(-32'sd3);
        // no rounds: row consumed silently
        configure(6'd3, 6'd0);
        send_sample(32'sd1);
        send_sample(32'sd2);
        send_sample(32'sd3);
        // row length lowered below the fill level mid-row
        configure(6'd6, 6'd3);
        send_sample(32'sd10);
        send_sample(-32'sd20);
        send_sample(32'sd30);
        send_sample(32'sd5);
        quiesce();
        write_reg(REG_ROW_LENGTH, 6'd2);
        send_sample(32'sd99);
        // repeated maxima: highest index cleared first
        configure(6'd4, 6'd4);
        send_sample(32'sd9);
        send_sample(32'sd9);
        send_sample(-32'sd1);
        send_sample(32'sd9);

        target = samples_sent + RANDOM_ITEMS;
        // saturating settings
        configure(6'd63, 6'd63);
        send_row(32);
        configure(6'd32, 6'd33);
        send_row(32);
        configure(6'd1, 6'd32);
        send_row(2);
        configure(6'd1, 6'd0);
        send_row(3);
        // long output hold-off while rows keep coming
        configure(6'd4, 6'd8);
        hold_req = 1'b1;
        send_row(20);

        while (samples_sent < target) begin
            if (samples_sent >= target - 40) begin
                tail_part = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: rl = CFG_W'($urandom_range(9, 31));
                1: rl = CFG_W'($urandom_range(32, 63));
                default: rl = CFG_W'($urandom_range(0, 8));
            endcase
            case ($urandom_range(0, 9))
                0: ec = 6'd0;
                1, 2: ec = CFG_W'($urandom_range(11, 63));
                default: ec = CFG_W'($urandom_range(1, 10));
            endcase
            configure(rl, ec);
            len  = row_items(rl);
            rows = (len > 16) ? 1 : $urandom_range(1, 4);
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                send_row($urandom_range(1, len - 1));
            end else begin
                send_row(len * rows);
            end
        end

        quiesce();
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
